/* rtl/tmmh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmmh_pkg
// Shared types and codes for the spectrum trace max/min hold block.
// ----------------------------------------------------------------------------
package tmmh_pkg;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 12;
  localparam int LVL_W   = 16;
  localparam int ACC_W   = 18;
  localparam int MODE_W  = 2;
  localparam int PC_W    = 13;
  localparam int CFG_A_W = 1;

  localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_OFFSET = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MIN   = 2'd2;

  localparam logic [CFG_A_W-1:0] CFG_HOLD_MODE   = 1'b0;
  localparam logic [CFG_A_W-1:0] CFG_POINT_COUNT = 1'b1;

  localparam logic [MODE_W-1:0] HOLD_MODE_RST   = MODE_WRITE;
  localparam logic [PC_W-1:0]   POINT_COUNT_RST = 13'd4096;

  localparam logic signed [ACC_W:0] ACC_MIN = -19'sd65536;
  localparam logic signed [ACC_W:0] ACC_MAX = 19'sd65535;

  localparam logic signed [ACC_W:0] LVL_MAX = 19'sd32767;
  localparam logic signed [ACC_W:0] LVL_MIN = -19'sd32768;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        idx;
    logic signed [LVL_W-1:0] lvl;
    logic                    oor;
  } item_t;

  typedef struct packed {
    logic sweeping;
  } back_status_t;

endpackage

`default_nettype wire

/* rtl/tmmh_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmmh_queue
// Two-entry queue of classified items between the front and the back part.
// ----------------------------------------------------------------------------
module tmmh_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tmmh_pkg::item_t push_item,
  input  wire logic            pop,
  output tmmh_pkg::item_t      head,
  output logic                 full,
  output logic                 empty
);

  tmmh_pkg::item_t slots [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;

  assign head  = slots[rptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/tmmh_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmmh_front
// Input side: accept items, flag bins outside the trace, queue them up.
// ----------------------------------------------------------------------------
module tmmh_front #(
  parameter int NUM_POINTS = 4096
) (
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [31:0]                  s_tdata,  // bin_index, level
  input  wire logic [tmmh_pkg::OP_W-1:0]    s_tuser,  // operation
  input  wire logic [tmmh_pkg::PC_W-1:0]    point_count,
  input  wire tmmh_pkg::back_status_t       status,
  input  wire logic                         q_full,
  output logic                              push,
  output tmmh_pkg::item_t                   push_item
);

  localparam logic [16:0] NP = 17'(NUM_POINTS);

  logic [tmmh_pkg::IDX_W-1:0] idx;
  logic                       in_range;

  assign idx      = s_tdata[tmmh_pkg::IDX_W-1:0];
  assign in_range = (tmmh_pkg::PC_W'(idx) < point_count) && (17'(idx) < NP);

  assign s_tready = !q_full && !status.sweeping;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_item.op  = s_tuser;
    push_item.idx = idx;
    push_item.lvl = s_tdata[tmmh_pkg::IDX_W +: tmmh_pkg::LVL_W];
    push_item.oor = !in_range;
  end

endmodule

`default_nettype wire

/* rtl/tmmh_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmmh_back
// Execution side: trace memory read-modify-write, offset accumulator,
// clearing sweep and the output register.
// ----------------------------------------------------------------------------
module tmmh_back #(
  parameter int NUM_POINTS = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [tmmh_pkg::MODE_W-1:0]   hold_mode,
  input  wire logic                          q_empty,
  input  wire tmmh_pkg::item_t               q_item,
  output logic                               pop,
  output tmmh_pkg::back_status_t             status,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [23:0]                        m_tdata   // value, bin_valid, out_of_range
);

  localparam int AW = $clog2(NUM_POINTS);
  localparam int WW = tmmh_pkg::ACC_W + 1;
  localparam logic [AW-1:0] LAST = AW'(NUM_POINTS - 1);

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_HOLD  = 2'd3;

  logic [1:0]                              state;
  logic [1:0]                              state_next;
  logic [AW-1:0]                           cnt;
  tmmh_pkg::item_t                         cur;
  logic signed [tmmh_pkg::ACC_W-1:0]       acc;
  logic [WW-1:0]                           rd_word;
  logic [WW-1:0]                           mem [NUM_POINTS];

  logic signed [tmmh_pkg::ACC_W:0]         acc_sum;
  logic signed [tmmh_pkg::ACC_W-1:0]       acc_next;
  logic signed [tmmh_pkg::ACC_W-1:0]       stored;
  logic signed [tmmh_pkg::ACC_W:0]         cur_level;
  logic signed [tmmh_pkg::ACC_W:0]         lvl_ext;
  logic signed [tmmh_pkg::ACC_W:0]         rel_level;
  logic signed [tmmh_pkg::LVL_W-1:0]       shown;
  logic                                    take;

  logic signed [tmmh_pkg::LVL_W-1:0]       exec_value;
  logic                                    exec_valid;
  logic                                    exec_oor;
  logic signed [tmmh_pkg::LVL_W-1:0]       res_value;
  logic                                    res_valid;
  logic                                    res_oor;

  logic                                    out_free;
  logic                                    load_out;
  logic                                    mem_we;
  logic [AW-1:0]                           mem_waddr;
  logic [WW-1:0]                           mem_wdata;

  assign pop             = (state == S_IDLE) && !q_empty;
  assign status.sweeping = (state == S_SWEEP);
  assign out_free        = !m_tvalid || m_tready;
  assign load_out        = ((state == S_EXEC) || (state == S_HOLD)) && out_free;

  // offset accumulator, applied when the item leaves the queue
  assign acc_sum = (tmmh_pkg::ACC_W + 1)'(acc) + (tmmh_pkg::ACC_W + 1)'(q_item.lvl);

  always_comb begin
    if (acc_sum > tmmh_pkg::ACC_MAX) begin
      acc_next = tmmh_pkg::ACC_W'(tmmh_pkg::ACC_MAX);
    end else if (acc_sum < tmmh_pkg::ACC_MIN) begin
      acc_next = tmmh_pkg::ACC_W'(tmmh_pkg::ACC_MIN);
    end else begin
      acc_next = tmmh_pkg::ACC_W'(acc_sum);
    end
  end

  // hold decision and report
  assign stored    = rd_word[tmmh_pkg::ACC_W-1:0];
  assign cur_level = (tmmh_pkg::ACC_W + 1)'(stored) + (tmmh_pkg::ACC_W + 1)'(acc);
  assign lvl_ext   = (tmmh_pkg::ACC_W + 1)'(cur.lvl);
  assign rel_level = lvl_ext - (tmmh_pkg::ACC_W + 1)'(acc);

  always_comb begin
    if (cur_level > tmmh_pkg::LVL_MAX) begin
      shown = tmmh_pkg::LVL_W'(tmmh_pkg::LVL_MAX);
    end else if (cur_level < tmmh_pkg::LVL_MIN) begin
      shown = tmmh_pkg::LVL_W'(tmmh_pkg::LVL_MIN);
    end else begin
      shown = tmmh_pkg::LVL_W'(cur_level);
    end
  end

  always_comb begin
    take = 1'b1;
    if (rd_word[WW-1]) begin
      case (hold_mode)
        tmmh_pkg::MODE_MAX: take = (lvl_ext > cur_level);
        tmmh_pkg::MODE_MIN: take = (lvl_ext < cur_level);
        default:            take = 1'b1;
      endcase
    end
  end

  always_comb begin
    exec_value = '0;
    exec_valid = 1'b0;
    exec_oor   = 1'b0;
    if (cur.oor) begin
      exec_oor = 1'b1;
    end else if (cur.op == tmmh_pkg::OP_CLEAR) begin
      exec_valid = 1'b0;
    end else if ((cur.op == tmmh_pkg::OP_UPDATE) && take) begin
      exec_value = cur.lvl;
      exec_valid = 1'b1;
    end else if (rd_word[WW-1]) begin
      exec_value = shown;
      exec_valid = 1'b1;
    end
  end

  // memory write port: sweep clears, update writes
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = '0;
    if (state == S_SWEEP) begin
      mem_we = 1'b1;
    end else if ((state == S_EXEC) && (cur.op == tmmh_pkg::OP_UPDATE) && !cur.oor && take) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(cur.idx);
      mem_wdata = {1'b1, tmmh_pkg::ACC_W'(rel_level)};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_word <= mem[AW'(q_item.idx)];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_comb begin
    if (cur.op == tmmh_pkg::OP_CLEAR) begin
      state_next = S_SWEEP;
    end else begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_item;
    end
    if (state == S_EXEC) begin
      res_value <= exec_value;
      res_valid <= exec_valid;
      res_oor   <= exec_oor;
    end
    if ((state == S_EXEC) && out_free) begin
      m_tdata <= {6'b0, exec_oor, exec_valid, exec_value};
    end else if ((state == S_HOLD) && out_free) begin
      m_tdata <= {6'b0, res_oor, res_valid, res_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_SWEEP;
      cnt      <= '0;
      acc      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        if (q_item.op == tmmh_pkg::OP_OFFSET) begin
          acc <= acc_next;
        end else if (q_item.op == tmmh_pkg::OP_CLEAR) begin
          acc <= '0;
        end
      end
      case (state)
        S_SWEEP: begin
          if (cnt == LAST) begin
            state <= S_IDLE;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_IDLE: begin
          if (pop) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          cnt <= '0;
          if (out_free) begin
            state <= state_next;
          end else begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= state_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/trace_max_min_hold_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trace_max_min_hold_top
// Spectrum trace with max/min hold, global offset and clear.
//
// Input stream: s_tuser carries the operation (update, read, offset, clear),
// s_tdata the bin index and level. Every transfer in gives one transfer out
// on m_* with the bin's displayed level, its valid flag and an out-of-range
// flag. Hold mode and point count are set through cfg_wen/cfg_addr/cfg_wdata;
// the user must write them only while the block is idle, which the block
// itself does not enforce. An input transfer is written into the queue,
// popped with its trace memory read, then loaded into the output register
// in the execute state. Each item holds the trace memory (read, then write
// back) before the next is popped. After reset, and after every clear, a
// sweep marks all bins unwritten; s_tready is low during the sweep. A clear's
// own result is loaded into the output register before its sweep starts.
// A stalled receiver holds the result in the output register; the two-entry
// queue keeps taking input until it fills, then s_tready drops.
// ----------------------------------------------------------------------------
module trace_max_min_hold_top #(
  parameter int NUM_POINTS = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [31:0]                      s_tdata,   // bin_index, level
  input  wire logic [tmmh_pkg::OP_W-1:0]        s_tuser,   // operation
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [23:0]                           m_tdata,   // value, bin_valid, out_of_range
  input  wire logic                             cfg_wen,
  input  wire logic [tmmh_pkg::CFG_A_W-1:0]     cfg_addr,
  input  wire logic [tmmh_pkg::PC_W-1:0]        cfg_wdata
);

  logic [tmmh_pkg::MODE_W-1:0] hold_mode;
  logic [tmmh_pkg::PC_W-1:0]   point_count;

  tmmh_pkg::back_status_t status;
  tmmh_pkg::item_t        push_item;
  tmmh_pkg::item_t        q_item;
  logic                   push;
  logic                   pop;
  logic                   q_full;
  logic                   q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_mode   <= tmmh_pkg::HOLD_MODE_RST;
      point_count <= tmmh_pkg::POINT_COUNT_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        tmmh_pkg::CFG_HOLD_MODE:   hold_mode   <= cfg_wdata[tmmh_pkg::MODE_W-1:0];
        tmmh_pkg::CFG_POINT_COUNT: point_count <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  tmmh_front #(
    .NUM_POINTS (NUM_POINTS)
  ) u_front (
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .point_count (point_count),
    .status      (status),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  tmmh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  tmmh_back #(
    .NUM_POINTS (NUM_POINTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .hold_mode (hold_mode),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .pop       (pop),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire
